@@ hdl/bilinear_rgba_interpolator_core_defines.svh @@
// Assertion macros used by the interpolator RTL.
`ifndef BILINEAR_RGBA_INTERPOLATOR_CORE_DEFINES_SVH
`define BILINEAR_RGBA_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BRI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bri assertion failed");
// next-cycle implication
`define BRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bri assertion failed");
`else
`define BRI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BRI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/bri_pkg.sv @@
package bri_pkg;

    localparam int unsigned FRAC_BITS = 8;
    localparam int unsigned ONE       = 1 << FRAC_BITS;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NCHAN   = PIX_W / CHAN_W;
    localparam int unsigned NPIX    = 4;
    localparam int unsigned OFS_W   = 9;   // port width of offset_x / offset_y
    localparam int unsigned D_W     = FRAC_BITS + 1;
    localparam int unsigned CMP_W   = (OFS_W > D_W) ? OFS_W : D_W;
    localparam int unsigned W_W     = 2 * FRAC_BITS + 1;   // weight, holds ONE^2
    localparam int unsigned PROD_W  = CHAN_W + W_W;
    localparam int unsigned SUM_W   = PROD_W + 2;

    localparam int unsigned S_FIELDS_W = NPIX * PIX_W + 2 * OFS_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = PIX_W;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // neighbor order inside an item
    localparam int unsigned PIX_TL = 0;
    localparam int unsigned PIX_TR = 1;
    localparam int unsigned PIX_BL = 2;
    localparam int unsigned PIX_BR = 3;

    typedef struct packed {
        logic [NPIX-1:0][PIX_W-1:0] pix;
        logic [NPIX-1:0][W_W-1:0]   wgt;
    } bri_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } bri_qstat_t;

    function automatic logic [D_W-1:0] clamp_offset(input logic [OFS_W-1:0] raw);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(raw);
        if (ext > CMP_W'(ONE)) begin
            return D_W'(ONE);
        end
        return D_W'(ext);
    endfunction

endpackage

@@ hdl/bilinear_rgba_interpolator_core.sv @@
// Bilinear RGBA8888 interpolator.
// Slave channel (s_): one transaction carries the four neighbor pixels and the
// sub-pixel offsets dx, dy (8 fraction bits, 256 = one pixel, larger saturates).
// Master channel (m_): one transaction per input carries the blended pixel,
// in input order. Channel layout: red 7:0, green 15:8, blue 23:16, alpha 31:24.
// The result passes through the queue (front weight multiply into the
// queue), then a product stage and an adder/output stage. Throughput: one
// transaction per clock while the queue is not full and m_tready does not
// hold the output, set by the combinational front and the two-stage back pipeline.
// A 4-entry queue decouples front and back; s_tready drops only when it fills.
// When m_tready is low the output register holds its transaction, the back
// pipeline closes its bubbles and then stops, and the queue keeps taking
// inputs until full.
// Reset (aresetn low, synchronous): queue emptied, pipeline valids cleared,
// m_tvalid low. Queue storage and the product and pixel registers are not reset.
`include "bilinear_rgba_interpolator_core_defines.svh"

module bilinear_rgba_interpolator_core
    import bri_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, low bit up: top_left_pixel[31:0], top_right_pixel[31:0],
    // bottom_left_pixel[31:0], bottom_right_pixel[31:0], offset_x[8:0],
    // offset_y[8:0], zero padding
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: blended_pixel[31:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned OFSX_LSB = NPIX * PIX_W;
    localparam int unsigned OFSY_LSB = OFSX_LSB + OFS_W;

    logic [NPIX-1:0][PIX_W-1:0] pix_in;
    logic [OFS_W-1:0]           offset_x;
    logic [OFS_W-1:0]           offset_y;

    bri_item_t  front_item;
    bri_item_t  head_item;
    bri_qstat_t q_stat;
    logic       push, pop, back_ready;

    // unpack the input transaction
    always_comb begin
        for (int k = 0; k < NPIX; k++) begin
            pix_in[k] = s_tdata[k*PIX_W +: PIX_W];
        end
        offset_x = s_tdata[OFSX_LSB +: OFS_W];
        offset_y = s_tdata[OFSY_LSB +: OFS_W];
    end

    // front: offset clamp and bilinear weights
    bri_front u_front (
        .pix_in   (pix_in),
        .offset_x (offset_x),
        .offset_y (offset_y),
        .item     (front_item)
    );

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;
    assign pop      = !q_stat.empty && back_ready;

    bri_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // back: per-channel products, weighted sum, truncation, output register
    bri_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!q_stat.empty),
        .in_ready  (back_ready),
        .in_item   (head_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata)
    );

    // queue bookkeeping
    `BRI_ASSERT_IMPL(a_q_bound, aclk, aresetn, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
    `BRI_ASSERT_NEXT(a_q_grow, aclk, aresetn, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1)
    `BRI_ASSERT_NEXT(a_q_idle, aclk, aresetn, q_stat.empty && !push, q_stat.empty)

endmodule

@@ hdl/bri_front.sv @@
module bri_front
    import bri_pkg::*;
(
    input  logic [NPIX-1:0][PIX_W-1:0] pix_in,
    input  logic [OFS_W-1:0]           offset_x,
    input  logic [OFS_W-1:0]           offset_y,
    output bri_item_t                  item
);

    logic [D_W-1:0] dx, dy, dx_inv, dy_inv;

    always_comb begin
        dx     = clamp_offset(offset_x);
        dy     = clamp_offset(offset_y);
        dx_inv = D_W'(ONE) - dx;
        dy_inv = D_W'(ONE) - dy;

        item.pix         = pix_in;
        item.wgt[PIX_TL] = W_W'(dx_inv) * W_W'(dy_inv);
        item.wgt[PIX_TR] = W_W'(dx) * W_W'(dy_inv);
        item.wgt[PIX_BL] = W_W'(dx_inv) * W_W'(dy);
        item.wgt[PIX_BR] = W_W'(dx) * W_W'(dy);
    end

endmodule

@@ hdl/bri_queue.sv @@
module bri_queue
    import bri_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  bri_item_t  push_item,
    input  logic       pop,
    output bri_item_t  head_item,
    output bri_qstat_t stat
);

    bri_item_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item  = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ hdl/bri_back.sv @@
module bri_back
    import bri_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bri_item_t            in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     out_pixel
);

    // stage 1: channel x weight products
    logic [NCHAN-1:0][NPIX-1:0][PROD_W-1:0] prod_reg, prod_next;
    logic                                   prod_vld_reg;
    // stage 2: summed, truncated, repacked
    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic             out_vld_reg;

    logic out_en, prod_en;

    assign out_en   = !out_vld_reg || out_ready;
    assign prod_en  = !prod_vld_reg || out_en;
    assign in_ready = prod_en;

    always_comb begin
        for (int c = 0; c < NCHAN; c++) begin
            for (int k = 0; k < NPIX; k++) begin
                prod_next[c][k] = PROD_W'(in_item.pix[k][c*CHAN_W +: CHAN_W])
                                * PROD_W'(in_item.wgt[k]);
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        for (int c = 0; c < NCHAN; c++) begin
            sum = (SUM_W'(prod_reg[c][PIX_TL]) + SUM_W'(prod_reg[c][PIX_TR]))
                + (SUM_W'(prod_reg[c][PIX_BL]) + SUM_W'(prod_reg[c][PIX_BR]));
            pixel_next[c*CHAN_W +: CHAN_W] = sum[2*FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg <= prod_next;
        end
        if (out_en) begin
            pixel_reg <= pixel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_vld_reg <= in_valid;
            end
            if (out_en) begin
                out_vld_reg <= prod_vld_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_pixel = pixel_reg;

endmodule
